// ----- hdl/stsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Trace span renderer package
// Shared constants, command record and small helpers for the span renderer.
// ----------------------------------------------------------------------------
package stsr_pkg;

	// Screen geometry and converter width
	localparam int NUM_COLUMNS  = 160;
	localparam int FIRST_COLUMN = 5;
	localparam int SAMPLE_BITS  = 12;

	// Field widths
	localparam int COL_W     = $clog2(NUM_COLUMNS);
	localparam int OUT_COL_W = 8;
	localparam int ROW_W     = 7;
	localparam int COLOR_W   = 16;
	localparam int SPAN_W    = 7;
	localparam int PROD_W    = SAMPLE_BITS + SPAN_W;
	localparam int QUO_W     = PROD_W - SAMPLE_BITS;
	localparam int REM_W     = SAMPLE_BITS + 1;

	// Row scaling
	localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
	localparam int ROW_BASE   = 123;
	localparam int DOT_SPAN   = 123;
	localparam int LINE_SPAN  = 97;

	// Configuration registers
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COLOR_W;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_COLOR = 1'd1;
	localparam logic                 TRACE_MODE_RESET  = 1'b1;
	localparam logic [COLOR_W-1:0]   TRACE_COLOR_RESET = 16'h7800;

	// Trace modes and input actions
	localparam logic MODE_DOT    = 1'b0;
	localparam logic MODE_LINE   = 1'b1;
	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// One classified column: optional erase span plus the draw span
	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic               erase;
		logic [ROW_W-1:0]   erase_lo;
		logic [ROW_W-1:0]   erase_hi;
		logic [ROW_W-1:0]   draw_lo;
		logic [ROW_W-1:0]   draw_hi;
		logic [COLOR_W-1:0] color;
	} stsr_cmd_t;

	function automatic logic [ROW_W-1:0] row_min(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [ROW_W-1:0] row_max(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b);
		return (a < b) ? b : a;
	endfunction

endpackage

// ----- hdl/stsr_ifs.sv -----
// ----------------------------------------------------------------------------
// Trace span renderer channels
// Valid/ready channels for incoming samples and outgoing span commands.
// ----------------------------------------------------------------------------

// Sample channel: one converter reading or a restart per item
interface stsr_sample_if;
	import stsr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   action;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink   (input valid, input action, input sample, output ready);
endinterface

// Span channel: one vertical span per item
interface stsr_span_if;
	import stsr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OUT_COL_W-1:0] column;
	logic [ROW_W-1:0]     row_low;
	logic [ROW_W-1:0]     row_high;
	logic [COLOR_W-1:0]   pixel_color;
	logic                 last;

	modport source (output valid, output column, output row_low, output row_high,
		output pixel_color, output last, input ready);
	modport sink   (input valid, input column, input row_low, input row_high,
		input pixel_color, input last, output ready);
endinterface

// ----- hdl/stsr_front.sv -----
// ----------------------------------------------------------------------------
// Trace span renderer front end
// Tracks the sweep column, scales samples to rows, keeps the line store and
// classifies each column into an erase/draw command for the queue.
// ----------------------------------------------------------------------------
module stsr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	stsr_sample_if.sink                 sample_ch,
	input  logic                        trace_mode,
	input  logic [stsr_pkg::COLOR_W-1:0] trace_color,
	output stsr_pkg::stsr_cmd_t         cmd,
	output logic                        cmd_push,
	input  logic                        cmd_full
);
	import stsr_pkg::*;

	logic                 accept;
	logic                 advance;
	logic [COL_W-1:0]     col_q;
	logic                 sweep_done_q;
	logic [ROW_W-1:0]     prev_new_q;
	logic [ROW_W-1:0]     prev_old_q;

	logic                 valid_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 first_s1;
	logic                 sweep_s1;
	logic                 mode_s1;
	logic [COLOR_W-1:0]   color_s1;
	logic [PROD_W-1:0]    prod_s1;
	logic [ROW_W-1:0]     old_row_s1;

	logic [ROW_W-1:0]     line_mem [NUM_COLUMNS];

	logic [SPAN_W-1:0]    span;
	logic [QUO_W-1:0]     quo_est;
	logic [REM_W-1:0]     rem;
	logic                 corr;
	logic [QUO_W-1:0]     quo;
	logic [ROW_W-1:0]     new_row;
	logic                 connect;

	// Handshake: stage 1 drains into the queue whenever there is room
	assign advance         = valid_s1 && !cmd_full;
	assign sample_ch.ready = !valid_s1 || !cmd_full;
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign cmd_push        = advance;

	// Scale factor for the current mode
	assign span = (trace_mode == MODE_LINE) ? SPAN_W'(LINE_SPAN) : SPAN_W'(DOT_SPAN);

	// Sweep position and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= COL_W'(FIRST_COLUMN);
			sweep_done_q <= 1'b0;
		end else if (accept) begin
			if (sample_ch.action == ACT_RESTART) begin
				col_q        <= COL_W'(FIRST_COLUMN);
				sweep_done_q <= 1'b0;
			end else if (col_q == COL_W'(NUM_COLUMNS - 1)) begin
				col_q        <= COL_W'(FIRST_COLUMN);
				sweep_done_q <= 1'b1;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (sample_ch.action == ACT_SAMPLE);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload: product registered straight after the multiplier
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col_q;
			first_s1 <= (col_q == COL_W'(FIRST_COLUMN));
			sweep_s1 <= sweep_done_q;
			mode_s1  <= trace_mode;
			color_s1 <= trace_color;
			prod_s1  <= PROD_W'(sample_ch.sample) * PROD_W'(span);
		end
	end

	// Line store: read on accept, write the new row as the command leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			old_row_s1 <= line_mem[col_q];
		end
		if (advance) begin
			line_mem[col_s1] <= new_row;
		end
	end

	// Divide by full scale: x = q*2^B + r  ->  x = q*(2^B-1) + (r + q)
	assign quo_est = prod_s1[PROD_W-1:SAMPLE_BITS];
	assign rem     = {1'b0, prod_s1[SAMPLE_BITS-1:0]} + REM_W'(quo_est);
	assign corr    = (rem >= REM_W'(FULL_SCALE));
	assign quo     = quo_est + QUO_W'(corr);
	assign new_row = ROW_W'(ROW_BASE) - ROW_W'(quo);

	// Previous column rows for connected spans
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_new_q <= '0;
			prev_old_q <= '0;
		end else if (advance) begin
			prev_new_q <= new_row;
			prev_old_q <= old_row_s1;
		end
	end

	// Classify: single pixels in dot mode and at the first column
	assign connect = (mode_s1 == MODE_LINE) && !first_s1;

	always_comb begin
		cmd.col   = col_s1;
		cmd.erase = sweep_s1;
		cmd.color = color_s1;
		if (connect) begin
			cmd.erase_lo = row_min(prev_old_q, old_row_s1);
			cmd.erase_hi = row_max(prev_old_q, old_row_s1);
			cmd.draw_lo  = row_min(prev_new_q, new_row);
			cmd.draw_hi  = row_max(prev_new_q, new_row);
		end else begin
			cmd.erase_lo = old_row_s1;
			cmd.erase_hi = old_row_s1;
			cmd.draw_lo  = new_row;
			cmd.draw_hi  = new_row;
		end
	end

	// A sweep completes only by wrapping to the first column
	a_done_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sweep_done_q) |-> (col_q == COL_W'(FIRST_COLUMN)))
		else $error("sweep done set away from first column");

	// One correction step leaves a proper remainder
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((corr ? (rem - REM_W'(FULL_SCALE)) : rem) < REM_W'(FULL_SCALE)))
		else $error("row scaling remainder out of range");

endmodule

// ----- hdl/stsr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// Trace span renderer command queue
// Short queue of classified column commands between front and back end.
// ----------------------------------------------------------------------------
module stsr_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  stsr_pkg::stsr_cmd_t wr_data,
	output logic                full,
	input  logic                pop,
	output stsr_pkg::stsr_cmd_t rd_data,
	output logic                empty
);
	import stsr_pkg::*;

	stsr_cmd_t               entries [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [CMDQ_CNT_W-1:0]   count_q;

	assign full    = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entries[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CMDQ_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CMDQ_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("command queue underflow");

endmodule

// ----- hdl/stsr_back.sv -----
// ----------------------------------------------------------------------------
// Trace span renderer back end
// Expands each queued command into a draw span, preceded by an erase span
// when the erase flag is set, and holds them in the output register.
// ----------------------------------------------------------------------------
module stsr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  stsr_pkg::stsr_cmd_t cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	stsr_span_if.source         span_ch
);
	import stsr_pkg::*;

	logic                 load;
	logic                 emit;
	logic                 do_erase;
	logic                 phase_q;
	logic                 out_valid_q;
	logic [OUT_COL_W-1:0] column_q;
	logic [ROW_W-1:0]     row_low_q;
	logic [ROW_W-1:0]     row_high_q;
	logic [COLOR_W-1:0]   color_q;
	logic                 last_q;

	// Output register takes a new span when empty or being drained
	assign load     = !out_valid_q || span_ch.ready;
	assign emit     = load && !cmd_empty;
	assign do_erase = cmd.erase && !phase_q;
	assign cmd_pop  = emit && !do_erase;

	// Control: output valid and erase-issued phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !cmd_empty;
			end
			if (emit) begin
				phase_q <= do_erase;
			end
		end
	end

	// Span payload
	always_ff @(posedge clk) begin
		if (emit) begin
			column_q <= OUT_COL_W'(cmd.col);
			last_q   <= !do_erase;
			if (do_erase) begin
				row_low_q  <= cmd.erase_lo;
				row_high_q <= cmd.erase_hi;
				color_q    <= '0;
			end else begin
				row_low_q  <= cmd.draw_lo;
				row_high_q <= cmd.draw_hi;
				color_q    <= cmd.color;
			end
		end
	end

	assign span_ch.valid       = out_valid_q;
	assign span_ch.column      = column_q;
	assign span_ch.row_low     = row_low_q;
	assign span_ch.row_high    = row_high_q;
	assign span_ch.pixel_color = color_q;
	assign span_ch.last        = last_q;

	// A pending erase span always has its draw still queued behind it
	a_erase_then_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (phase_q && !cmd_empty))
		else $error("erase span issued without its draw");

endmodule

// ----- hdl/scope_trace_span_renderer.sv -----
// ----------------------------------------------------------------------------
// Trace span renderer top level
// Converts a sample stream into erase/draw vertical span items for a
// sweeping trace, one column per sample.
// ----------------------------------------------------------------------------
//  channel    dir  item                                         handshake
//  sample_ch  in   action, sample                               valid/ready
//  span_ch    out  column, row_low, row_high, pixel_color, last valid/ready
//  cfg        in   cfg_index, cfg_data                          cfg_we, no wait
//
//  A sample item is taken every cycle while the two-entry command queue has
//  room; the back end sends one span per cycle while span_ch is ready. A
//  sample gives an erase and a draw span (a draw span alone in the first
//  sweep) via stage 1, queue, output register. Restart items cause no span.
//  Reset does not clear the line store: the first sweep writes every column
//  before any erase reads it. Either side may stall without losing items.
// ----------------------------------------------------------------------------
module scope_trace_span_renderer (
	input  logic                            clk,
	input  logic                            arst_n,
	stsr_sample_if.sink                     sample_ch,
	stsr_span_if.source                     span_ch,
	input  logic                            cfg_we,
	input  logic [stsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import stsr_pkg::*;

	logic               trace_mode_q;
	logic [COLOR_W-1:0] trace_color_q;
	stsr_cmd_t          push_cmd;
	stsr_cmd_t          head_cmd;
	logic               cmd_push;
	logic               cmd_pop;
	logic               cmd_full;
	logic               cmd_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_mode_q  <= TRACE_MODE_RESET;
			trace_color_q <= TRACE_COLOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRACE_MODE:  trace_mode_q  <= cfg_data[0];
				REG_TRACE_COLOR: trace_color_q <= COLOR_W'(cfg_data);
				default: ;
			endcase
		end
	end

	stsr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_ch   (sample_ch),
		.trace_mode  (trace_mode_q),
		.trace_color (trace_color_q),
		.cmd         (push_cmd),
		.cmd_push    (cmd_push),
		.cmd_full    (cmd_full)
	);

	stsr_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (push_cmd),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (head_cmd),
		.empty   (cmd_empty)
	);

	stsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.span_ch   (span_ch)
	);

endmodule
